@@ rtl/assert_macros.svh @@
// Assertion macros for the GPS timestamp record checker.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GTRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define GTRC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/gtrc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the GPS timestamp record checker.
// No dependencies.
package gtrc_pkg;

  localparam int unsigned RecLen    = 22;
  localparam int unsigned PosQual   = 13;
  localparam int unsigned PosW      = 5;
  localparam int unsigned SecW      = 28;
  localparam int unsigned TickW     = 64;
  localparam int unsigned CountW    = 9;
  localparam int unsigned WeightW   = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [PosW-1:0] LastPos  = PosW'(RecLen - 1);
  localparam logic [PosW-1:0] QualPos  = PosW'(PosQual);
  localparam logic [PosW-1:0] Colon0   = 5'd4;
  localparam logic [PosW-1:0] Colon1   = 5'd7;
  localparam logic [PosW-1:0] Colon2   = 5'd10;
  localparam logic [SecW-1:0] DaySecs  = 28'd86400;
  localparam logic [7:0]      SohByte  = 8'h01;
  localparam logic [7:0]      ColonChr = 8'h3A;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLAG_TICK  = 3'd0,
    CFG_STOP_TICK  = 3'd1,
    CFG_FLAG_GPS   = 3'd2,
    CFG_SKIP       = 3'd3,
    CFG_EXP_DELTA  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    QUAL_SPACE   = 3'd0,
    QUAL_DOT     = 3'd1,
    QUAL_STAR    = 3'd2,
    QUAL_HASH    = 3'd3,
    QUAL_QUERY   = 3'd4,
    QUAL_UNKNOWN = 3'd5
  } qual_e;

  typedef struct packed {
    logic        flag_tick;
    logic        stop_tick;
    logic        flag_gps;
    logic [7:0]  skip;
    logic [31:0] exp_delta;
  } gtrc_cfg_t;

  // Fields of a completed record, valid when done is set
  typedef struct packed {
    logic             done;
    logic [SecW-1:0]  sec_acc;
    logic [TickW-1:0] tick;
    logic [2:0]       qual;
    logic             fmt_bad;
  } gtrc_rec_t;

  typedef struct packed {
    logic [SecW-1:0]  gps_seconds;
    logic [2:0]       time_quality;
    logic [TickW-1:0] tick_time;
    logic [TickW-1:0] tick_delta;
    logic             delta_valid;
    logic             format_error;
    logic             bad_tick_delta;
    logic             bad_gps_delta;
    logic             halted;
    logic             any_bad_delta;
  } gtrc_res_t;

  function automatic logic [WeightW-1:0] digit_weight(input logic [PosW-1:0] pos);
    logic [WeightW-1:0] w;
    unique case (pos)
      5'd1:    w = 24'd8640000;
      5'd2:    w = 24'd864000;
      5'd3:    w = 24'd86400;
      5'd5:    w = 24'd36000;
      5'd6:    w = 24'd3600;
      5'd8:    w = 24'd600;
      5'd9:    w = 24'd60;
      5'd11:   w = 24'd10;
      5'd12:   w = 24'd1;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] sat_digit(input logic [7:0] b);
    logic [3:0] d;
    priority if (b < 8'h30) d = 4'd0;
    else if (b > 8'h39)     d = 4'd9;
    else                    d = b[3:0];
    return d;
  endfunction

  function automatic qual_e qual_code(input logic [7:0] b);
    qual_e q;
    unique case (b)
      8'h20:   q = QUAL_SPACE;
      8'h2E:   q = QUAL_DOT;
      8'h2A:   q = QUAL_STAR;
      8'h23:   q = QUAL_HASH;
      8'h3F:   q = QUAL_QUERY;
      default: q = QUAL_UNKNOWN;
    endcase
    return q;
  endfunction

endpackage

@@ rtl/gps_timestamp_record_checker_unit.sv @@
`timescale 1ns / 1ps
// Top level of the GPS timestamp record checker: input stage, config registers, result stage.
// Depends on gtrc_pkg, gtrc_frame, gtrc_check and assert_macros.svh.
`include "assert_macros.svh"
// One byte beat is taken per cycle unless the input stalls; a byte is held in the input
// register, then parsed into the result register, which takes the result from the last
// byte of its record (byte 21, or the 22nd byte after a record_start). The only loop is the
// per-byte accumulator update in gtrc_frame, one step a cycle unless stalled. A result beat
// that is not taken stalls the input after one more byte. Once stop mode trips, every later
// byte is taken and dropped until reset. Configuration writes take effect on the next cycle.
module gps_timestamp_record_checker_unit import gtrc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                record_start_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [SecW-1:0] gps_seconds_o,
  output logic [2:0]          time_quality_o,
  output logic [TickW-1:0]    tick_time_o,
  output logic [TickW-1:0]    tick_delta_o,
  output logic                delta_valid_o,
  output logic                format_error_o,
  output logic                bad_tick_delta_o,
  output logic                bad_gps_delta_o,
  output logic                halted_o,
  output logic                any_bad_delta_o
);

  gtrc_cfg_t cfg_q;
  logic      s1_valid_q;
  logic [7:0] s1_byte_q;
  logic      s1_start_q;
  logic      res_valid_q;
  gtrc_res_t res_q;
  gtrc_rec_t rec;
  gtrc_res_t res;
  logic      stopped;
  logic      s2_adv, fire, step, commit;

  assign s2_adv     = !res_valid_q || out_ready_i;
  assign fire       = s1_valid_q && s2_adv;
  assign step       = fire && !stopped;
  assign commit     = step && rec.done;
  assign in_ready_o = !s1_valid_q || s2_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_tick <= 1'b0;
      cfg_q.stop_tick <= 1'b0;
      cfg_q.flag_gps  <= 1'b0;
      cfg_q.skip      <= 8'd15;
      cfg_q.exp_delta <= 32'd20000000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLAG_TICK: cfg_q.flag_tick <= cfg_data_i[0];
        CFG_STOP_TICK: cfg_q.stop_tick <= cfg_data_i[0];
        CFG_FLAG_GPS:  cfg_q.flag_gps  <= cfg_data_i[0];
        CFG_SKIP:      cfg_q.skip      <= cfg_data_i[7:0];
        CFG_EXP_DELTA: cfg_q.exp_delta <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (commit)           res_valid_q <= 1'b1;
      else if (out_ready_i) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= rx_byte_i;
      s1_start_q <= record_start_i;
    end
    if (commit) res_q <= res;
  end

  gtrc_frame u_frame (
    .clk_i,
    .rst_ni,
    .step_i         (step),
    .rx_byte_i      (s1_byte_q),
    .record_start_i (s1_start_q),
    .rec_o          (rec)
  );

  gtrc_check u_check (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg_q),
    .commit_i  (commit),
    .rec_i     (rec),
    .res_o     (res),
    .stopped_o (stopped)
  );

  assign out_valid_o      = res_valid_q;
  assign gps_seconds_o    = res_q.gps_seconds;
  assign time_quality_o   = res_q.time_quality;
  assign tick_time_o      = res_q.tick_time;
  assign tick_delta_o     = res_q.tick_delta;
  assign delta_valid_o    = res_q.delta_valid;
  assign format_error_o   = res_q.format_error;
  assign bad_tick_delta_o = res_q.bad_tick_delta;
  assign bad_gps_delta_o  = res_q.bad_gps_delta;
  assign halted_o         = res_q.halted;
  assign any_bad_delta_o  = res_q.any_bad_delta;

  `GTRC_ASSERT(a_halt_needs_stop_mode, $rose(stopped) |-> $past(cfg_q.stop_tick), "halt without stop mode")
  `GTRC_ASSERT(a_no_result_after_halt, (stopped && !res_valid_q) |=> !res_valid_q, "result after halt")
  `GTRC_ASSERT(a_s1_holds_on_stall, (s1_valid_q && !s2_adv) |=> (s1_valid_q && $stable(s1_byte_q)), "input stage lost a beat")
  `GTRC_NEVER(a_bad_not_sticky, res_valid_q && (res_q.bad_tick_delta || res_q.bad_gps_delta) && !res_q.any_bad_delta, "sticky flag missing")

endmodule

@@ rtl/gtrc_frame.sv @@
`timescale 1ns / 1ps
// Record framing and field accumulation: byte position, time digits, quality, ticks.
// Depends on gtrc_pkg.
module gtrc_frame import gtrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  input  logic       record_start_i,
  output gtrc_rec_t  rec_o
);

  logic [PosW-1:0]  pos_q, pos_d, pos_eff;
  logic [SecW-1:0]  sec_q, sec_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [2:0]       qual_q, qual_d;
  logic             fmt_q, fmt_d;
  logic [SecW-1:0]  digit_term;
  logic             done;

  assign pos_eff    = record_start_i ? '0 : pos_q;
  assign digit_term = SecW'(sat_digit(rx_byte_i)) * SecW'(digit_weight(pos_eff));
  assign done       = (pos_eff >= LastPos);

  always_comb begin
    sec_d  = sec_q;
    tick_d = tick_q;
    qual_d = qual_q;
    fmt_d  = fmt_q;
    priority if (pos_eff == '0) begin
      sec_d  = '0;
      tick_d = '0;
      qual_d = QUAL_SPACE;
      fmt_d  = (rx_byte_i != SohByte);
    end else if (pos_eff == Colon0 || pos_eff == Colon1 || pos_eff == Colon2) begin
      fmt_d = fmt_q | (rx_byte_i != ColonChr);
    end else if (pos_eff < QualPos) begin
      sec_d = sec_q + digit_term;
    end else if (pos_eff == QualPos) begin
      qual_d = qual_code(rx_byte_i);
    end else begin
      tick_d = {tick_q[TickW-9:0], rx_byte_i};
    end
    pos_d = done ? '0 : pos_eff + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sec_q  <= '0;
      tick_q <= '0;
      qual_q <= '0;
      fmt_q  <= 1'b0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      sec_q  <= sec_d;
      tick_q <= tick_d;
      qual_q <= qual_d;
      fmt_q  <= fmt_d;
    end
  end

  assign rec_o.done    = done;
  assign rec_o.sec_acc = sec_d;
  assign rec_o.tick    = tick_d;
  assign rec_o.qual    = qual_d;
  assign rec_o.fmt_bad = fmt_d;

endmodule

@@ rtl/gtrc_check.sv @@
`timescale 1ns / 1ps
// Per-record delta checks, history, record count, halt and sticky error state.
// Depends on gtrc_pkg.
module gtrc_check import gtrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  gtrc_cfg_t cfg_i,
  input  logic      commit_i,
  input  gtrc_rec_t rec_i,
  output gtrc_res_t res_o,
  output logic      stopped_o
);

  logic [TickW-1:0]  prev_tick_q;
  logic [SecW-1:0]   prev_sec_q;
  logic              have_prev_q;
  logic [CountW-1:0] count_q;
  logic              stopped_q, stopped_d;
  logic              sticky_q, sticky_d;

  logic [SecW-1:0]   secs;
  logic [TickW-1:0]  delta;
  logic [SecW:0]     sec_diff;
  logic              past_skip, bad_tick, bad_gps;

  assign secs      = rec_i.sec_acc - DaySecs;
  assign delta     = have_prev_q ? rec_i.tick - prev_tick_q : '0;
  assign sec_diff  = {secs[SecW-1], secs} - {prev_sec_q[SecW-1], prev_sec_q};
  assign past_skip = count_q > {1'b0, cfg_i.skip};

  assign bad_tick  = (cfg_i.flag_tick | cfg_i.stop_tick) && past_skip &&
                     (delta != {32'b0, cfg_i.exp_delta});
  assign bad_gps   = cfg_i.flag_gps && have_prev_q && past_skip && (secs != '0) &&
                     (sec_diff != (SecW+1)'(1));
  assign stopped_d = stopped_q | (cfg_i.stop_tick & bad_tick);
  assign sticky_d  = sticky_q | bad_tick | bad_gps;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_tick_q <= '0;
      prev_sec_q  <= '0;
      have_prev_q <= 1'b0;
      count_q     <= '0;
      stopped_q   <= 1'b0;
      sticky_q    <= 1'b0;
    end else if (commit_i) begin
      prev_tick_q <= rec_i.tick;
      prev_sec_q  <= secs;
      have_prev_q <= 1'b1;
      if (count_q != CountMax) count_q <= count_q + 1'b1;
      stopped_q   <= stopped_d;
      sticky_q    <= sticky_d;
    end
  end

  assign res_o.gps_seconds    = secs;
  assign res_o.time_quality   = rec_i.qual;
  assign res_o.tick_time      = rec_i.tick;
  assign res_o.tick_delta     = delta;
  assign res_o.delta_valid    = have_prev_q;
  assign res_o.format_error   = rec_i.fmt_bad;
  assign res_o.bad_tick_delta = bad_tick;
  assign res_o.bad_gps_delta  = bad_gps;
  assign res_o.halted         = stopped_d;
  assign res_o.any_bad_delta  = sticky_d;

  assign stopped_o = stopped_q;

endmodule
